// ----- hw/rtl/mck_pkg.sv -----
// Shared types, constants and the Morse code table of the character keyer.
package mck_pkg;

  // Width of the duration field on the result stream
  localparam int OUT_DUR_W = 16;

  // Longest Morse code in the table (digits)
  localparam int CODE_MAX = 5;
  localparam int CODE_LEN_W = $clog2(CODE_MAX + 1);

  // Characters with special handling
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DOT      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DASH     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ELEM_GAP = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LTR_GAP  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WORD_GAP = 3'd4;

  // Register reset values, time units
  localparam int DOT_RST      = 200;
  localparam int DASH_RST     = 600;
  localparam int ELEM_GAP_RST = 200;
  localparam int LTR_GAP_RST  = 600;
  localparam int WORD_GAP_RST = 1400;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_MARK,
    ST_EGAP,
    ST_WORD,
    ST_CLOSE
  } state_t;

  // Kind of segment to load into the output register
  typedef enum logic [1:0] {
    SEG_LETTER,
    SEG_ELEMENT,
    SEG_WORD,
    SEG_MARK
  } seg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic emit;
    seg_t seg;
    logic last;
    logic step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic lead;
    logic len_zero;
    logic idx_last;
    logic space;
    logic eom;
  } sts_t;

  // One table entry: element count and pattern, first element in the MSB, 1 = dash
  typedef struct packed {
    logic [CODE_LEN_W-1:0] len;
    logic [CODE_MAX-1:0]   pat;
  } code_t;

  function automatic code_t code_lookup(input logic [7:0] ch);
    code_t c;
    c = '{len: '0, pat: '0};
    case (ch)
      8'h61: c = '{len: 3'd2, pat: 5'b01000}; // a
      8'h62: c = '{len: 3'd4, pat: 5'b10000}; // b
      8'h63: c = '{len: 3'd4, pat: 5'b10100}; // c
      8'h64: c = '{len: 3'd3, pat: 5'b10000}; // d
      8'h65: c = '{len: 3'd1, pat: 5'b00000}; // e
      8'h66: c = '{len: 3'd4, pat: 5'b00100}; // f
      8'h67: c = '{len: 3'd3, pat: 5'b11000}; // g
      8'h68: c = '{len: 3'd4, pat: 5'b00000}; // h
      8'h69: c = '{len: 3'd2, pat: 5'b00000}; // i
      8'h6A: c = '{len: 3'd4, pat: 5'b01110}; // j
      8'h6B: c = '{len: 3'd3, pat: 5'b10100}; // k
      8'h6C: c = '{len: 3'd4, pat: 5'b01000}; // l
      8'h6D: c = '{len: 3'd2, pat: 5'b11000}; // m
      8'h6E: c = '{len: 3'd2, pat: 5'b10000}; // n
      8'h6F: c = '{len: 3'd3, pat: 5'b11100}; // o
      8'h70: c = '{len: 3'd4, pat: 5'b01100}; // p
      8'h71: c = '{len: 3'd4, pat: 5'b11010}; // q
      8'h72: c = '{len: 3'd3, pat: 5'b01000}; // r
      8'h73: c = '{len: 3'd3, pat: 5'b00000}; // s
      8'h74: c = '{len: 3'd1, pat: 5'b10000}; // t
      8'h75: c = '{len: 3'd3, pat: 5'b00100}; // u
      8'h76: c = '{len: 3'd4, pat: 5'b00010}; // v
      8'h77: c = '{len: 3'd3, pat: 5'b01100}; // w
      8'h78: c = '{len: 3'd4, pat: 5'b10010}; // x
      8'h79: c = '{len: 3'd4, pat: 5'b10110}; // y
      8'h7A: c = '{len: 3'd4, pat: 5'b11000}; // z
      8'h30: c = '{len: 3'd5, pat: 5'b11111}; // 0
      8'h31: c = '{len: 3'd5, pat: 5'b01111}; // 1
      8'h32: c = '{len: 3'd5, pat: 5'b00111}; // 2
      8'h33: c = '{len: 3'd5, pat: 5'b00011}; // 3
      8'h34: c = '{len: 3'd5, pat: 5'b00001}; // 4
      8'h35: c = '{len: 3'd5, pat: 5'b00000}; // 5
      8'h36: c = '{len: 3'd5, pat: 5'b10000}; // 6
      8'h37: c = '{len: 3'd5, pat: 5'b11000}; // 7
      8'h38: c = '{len: 3'd5, pat: 5'b11100}; // 8
      8'h39: c = '{len: 3'd5, pat: 5'b11110}; // 9
      default: c = '{len: '0, pat: '0};
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/mck_ctrl.sv -----
// Sequencing controller: walks one character through its keying segments.
module mck_ctrl
  import mck_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '{load: 1'b0, emit: 1'b0, seg: SEG_LETTER, last: 1'b0, step: 1'b0};
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LEAD;
        end
      end
      // letter gap ahead of a character inside a message
      ST_LEAD: begin
        if (!sts.lead || sts.slot_free) begin
          if (sts.lead) begin
            cmd.emit = 1'b1;
            cmd.seg  = SEG_LETTER;
            cmd.last = sts.len_zero && !sts.space && !sts.eom;
          end
          if (!sts.len_zero) begin
            state_nxt = ST_MARK;
          end else if (sts.space) begin
            state_nxt = ST_WORD;
          end else begin
            state_nxt = ST_CLOSE;
          end
        end
      end
      // dot or dash
      ST_MARK: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.seg   = SEG_MARK;
          cmd.last  = sts.idx_last && !sts.eom;
          cmd.step  = 1'b1;
          state_nxt = sts.idx_last ? ST_CLOSE : ST_EGAP;
        end
      end
      ST_EGAP: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.seg   = SEG_ELEMENT;
          state_nxt = ST_MARK;
        end
      end
      ST_WORD: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.seg   = SEG_WORD;
          cmd.last  = !sts.eom;
          state_nxt = ST_CLOSE;
        end
      end
      // closing letter gap at end of message
      ST_CLOSE: begin
        if (!sts.eom) begin
          state_nxt = ST_IDLE;
        end else if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.seg   = SEG_LETTER;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/mck_datapath.sv -----
// Datapath: timing registers, character plan and the output segment register.
module mck_datapath
  import mck_pkg::*;
#(
  parameter int DURATION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [7:0]               in_tdata,
  input  logic                     in_tlast,
  input  logic                     cfg_we,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [DURATION_BITS-1:0] cfg_wdata,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DUR_W-1:0]     out_tdata,
  output logic                     out_tuser,
  output logic                     out_tlast
);

  logic [DURATION_BITS-1:0] dot_r, dash_r, egap_r, lgap_r, wgap_r;
  logic                     in_msg_r;
  logic                     lead_r, space_r, eom_r;
  logic [CODE_LEN_W-1:0]    rem_r;
  logic [CODE_MAX-1:0]      pat_r;
  logic                     oval_r, olevel_r, olast_r;
  logic [OUT_DUR_W-1:0]     odur_r;

  code_t                            code;
  logic [DURATION_BITS-1:0]         dur_sel;
  logic                             lvl_sel;
  logic [DURATION_BITS+OUT_DUR_W-1:0] dur_ext;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= DURATION_BITS'(DOT_RST);
      dash_r <= DURATION_BITS'(DASH_RST);
      egap_r <= DURATION_BITS'(ELEM_GAP_RST);
      lgap_r <= DURATION_BITS'(LTR_GAP_RST);
      wgap_r <= DURATION_BITS'(WORD_GAP_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOT:      dot_r  <= cfg_wdata;
        REG_DASH:     dash_r <= cfg_wdata;
        REG_ELEM_GAP: egap_r <= cfg_wdata;
        REG_LTR_GAP:  lgap_r <= cfg_wdata;
        REG_WORD_GAP: wgap_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Message tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
    end else if (cmd.load) begin
      in_msg_r <= !in_tlast;
    end
  end

  assign code = code_lookup(in_tdata);

  // Character plan: latched on accept, pattern shifts out one element a step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lead_r  <= in_msg_r && (in_tdata != CHAR_SPACE) && (in_tdata != CHAR_NEWLINE);
      space_r <= (in_tdata == CHAR_SPACE);
      eom_r   <= in_tlast;
      rem_r   <= code.len;
      pat_r   <= code.pat;
    end else if (cmd.step) begin
      rem_r   <= rem_r - CODE_LEN_W'(1);
      pat_r   <= {pat_r[CODE_MAX-2:0], 1'b0};
    end
  end

  // Segment selection
  always_comb begin
    lvl_sel = 1'b0;
    dur_sel = lgap_r;
    case (cmd.seg)
      SEG_LETTER:  dur_sel = lgap_r;
      SEG_ELEMENT: dur_sel = egap_r;
      SEG_WORD:    dur_sel = wgap_r;
      SEG_MARK: begin
        lvl_sel = 1'b1;
        dur_sel = pat_r[CODE_MAX-1] ? dash_r : dot_r;
      end
      default: dur_sel = lgap_r;
    endcase
  end

  assign dur_ext = {{OUT_DUR_W{1'b0}}, dur_sel};

  // Output segment register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (cmd.emit) begin
      oval_r <= 1'b1;
    end else if (out_tready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      olevel_r <= lvl_sel;
      odur_r   <= dur_ext[OUT_DUR_W-1:0];
      olast_r  <= cmd.last;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = odur_r;
  assign out_tuser  = olevel_r;
  assign out_tlast  = olast_r;

  // Status to the controller
  assign sts = '{
    slot_free: !oval_r || out_tready,
    lead:      lead_r,
    len_zero:  (rem_r == '0),
    idx_last:  (rem_r == CODE_LEN_W'(1)),
    space:     space_r,
    eom:       eom_r
  };

endmodule

// ----- hw/rtl/morse_character_keyer.sv -----
// Top level of the Morse character keyer: controller plus datapath.
// Takes one ASCII character per input word and sends the keying segments
// (level, duration) that key it in International Morse: letters a-z and
// digits 0-9 as dots and dashes separated by element gaps, a space as a word
// gap, a letter gap ahead of every character of a message but the first
// (spaces and newlines excepted), and a closing letter gap after the word
// flagged by in_tlast. Other codes send no elements. One character is worked
// at a time: the controller accepts it, then steps through its segments and
// loads one segment per cycle into the single output register while the
// output side keeps up; a leading or closing gap that does not apply still
// takes its own controller state, and an output stall holds the controller.
// Configuration writes take effect at once and are meant for idle time.
module morse_character_keyer
  import mck_pkg::*;
#(
  parameter int DURATION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // character stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] char_code
  input  logic                     in_tlast,   // end_of_message
  // segment stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DUR_W-1:0]     out_tdata,  // [15:0] duration
  output logic                     out_tuser,  // [0] key_level
  output logic                     out_tlast,  // run_last
  // configuration writes
  input  logic                     cfg_we,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [DURATION_BITS-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  mck_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mck_datapath #(
    .DURATION_BITS (DURATION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- hw/rtl/mck_checker.sv -----
// Port-level checks of the Morse character keyer, bound to the top level.
module mck_checker
  import mck_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OUT_DUR_W-1:0] out_tdata,
  input logic                 out_tuser,
  input logic                 out_tlast
);

  // Reset leaves the block idle with nothing pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> in_tready && !out_tvalid)
    else $error("not idle after reset");

  // One character at a time: an accepted word leaves the input closed in the cycle after the handshake
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice back to back");

  // A stalled segment stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("segment dropped while stalled");

  // A stalled segment keeps its contents
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      ($stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("segment changed while stalled");

endmodule

bind morse_character_keyer mck_checker u_mck_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the Morse character keyer.
`timescale 1ns / 100ps

module tb_top;
  import mck_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_OFF_CYCLES = 300;

  // One expected keying segment
  typedef struct packed {
    logic                 level;
    logic [OUT_DUR_W-1:0] dur;
    logic                 last;
  } segment_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_DUR_W-1:0] out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_wdata = '0;

  // Shadow of the keyer: register file and message flag
  logic [15:0] dur_reg [0:4] = '{16'(DOT_RST), 16'(DASH_RST), 16'(ELEM_GAP_RST),
                                 16'(LTR_GAP_RST), 16'(WORD_GAP_RST)};
  logic        msg_open = 1'b0;

  segment_t pending_segs[$];
  segment_t want_seg;
  bit       failed = 1'b0;
  int       send_idle = 0;
  int       recv_stall = 0;
  int       hold_cycles = 0;
  int       quiet_cycles = 0;

  morse_character_keyer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Dots and dashes per character, empty for anything without a code
  function automatic string morse_pattern(input logic [7:0] ch);
    case (ch)
      "a": return ".-";    "b": return "-...";  "c": return "-.-.";  "d": return "-..";
      "e": return ".";     "f": return "..-.";  "g": return "--.";   "h": return "....";
      "i": return "..";    "j": return ".---";  "k": return "-.-";   "l": return ".-..";
      "m": return "--";    "n": return "-.";    "o": return "---";   "p": return ".--.";
      "q": return "--.-";  "r": return ".-.";   "s": return "...";   "t": return "-";
      "u": return "..-";   "v": return "...-";  "w": return ".--";   "x": return "-..-";
      "y": return "-.--";  "z": return "--..";
      "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
      "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
      "8": return "---.."; "9": return "----.";
      default: return "";
    endcase
  endfunction

  // Expected segments of one accepted character
  task automatic predict_keying(input logic [7:0] ch, input logic eom);
    segment_t segs[$];
    segment_t seg;
    string    pat;
    // leading letter gap inside a message
    if (msg_open && ch != CHAR_SPACE && ch != CHAR_NEWLINE)
      segs.push_back('{level: 1'b0, dur: dur_reg[REG_LTR_GAP], last: 1'b0});
    pat = morse_pattern(ch);
    for (int k = 0; k < pat.len(); k++) begin
      if (k > 0)
        segs.push_back('{level: 1'b0, dur: dur_reg[REG_ELEM_GAP], last: 1'b0});
      segs.push_back('{level: 1'b1, last: 1'b0,
                       dur: (pat[k] == "-") ? dur_reg[REG_DASH] : dur_reg[REG_DOT]});
    end
    if (ch == CHAR_SPACE)
      segs.push_back('{level: 1'b0, dur: dur_reg[REG_WORD_GAP], last: 1'b0});
    // closing gap ends the message
    if (eom) begin
      segs.push_back('{level: 1'b0, dur: dur_reg[REG_LTR_GAP], last: 1'b0});
      msg_open = 1'b0;
    end else begin
      msg_open = 1'b1;
    end
    foreach (segs[i]) begin
      seg = segs[i];
      seg.last = (i == segs.size() - 1);
      pending_segs.push_back(seg);
    end
  endtask

  // Offer one character, wait for the handshake, then predict
  task automatic send_char(input logic [7:0] ch, input logic eom);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= eom;
    do @(posedge clk); while (!in_tready);
    predict_keying(ch, eom);
  endtask

  // Stop offering, wait for all segments, let the block go idle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; cfg_we stays high for back to back writes
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx <= REG_WORD_GAP)
      dur_reg[idx] = val;
  endtask

  task automatic set_regs(input logic [15:0] dot, input logic [15:0] dash,
                          input logic [15:0] egap, input logic [15:0] lgap,
                          input logic [15:0] wgap);
    write_reg(REG_DOT, dot);
    write_reg(REG_DASH, dash);
    write_reg(REG_ELEM_GAP, egap);
    write_reg(REG_LTR_GAP, lgap);
    write_reg(REG_WORD_GAP, wgap);
    cfg_we <= 1'b0;
  endtask

  // Mostly message text, some arbitrary codes
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 45)      return 8'("a" + $urandom_range(25));
    else if (r < 65) return 8'("0" + $urandom_range(9));
    else if (r < 80) return CHAR_SPACE;
    else if (r < 85) return CHAR_NEWLINE;
    else             return 8'($urandom_range(255));
  endfunction

  // Reset values, every code kind, message boundaries
  task automatic test_directed();
    send_char("e", 1'b0);
    send_char("t", 1'b0);
    send_char("a", 1'b0);
    send_char("z", 1'b0);
    send_char("0", 1'b0);
    send_char("9", 1'b0);
    send_char("3", 1'b0);
    send_char("8", 1'b1);
    send_char(CHAR_SPACE, 1'b0);
    send_char("q", 1'b0);
    send_char(CHAR_NEWLINE, 1'b0);
    send_char("A", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CHAR_SPACE, 1'b1);
    send_char(CHAR_NEWLINE, 1'b1);
    send_char(8'h7B, 1'b1);
    send_char("5", 1'b1);
    send_char("k", 1'b0);
    send_char("0", 1'b1);
    send_char(CHAR_NEWLINE, 1'b0);
    send_char("b", 1'b1);
    drain_results();
  endtask

  task automatic send_probe_text();
    send_char("o", 1'b0);
    send_char("e", 1'b0);
    send_char(CHAR_SPACE, 1'b0);
    send_char("5", 1'b1);
    drain_results();
  endtask

  // Register extremes, zero lengths, writes past the register list
  task automatic test_register_extremes();
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_probe_text();
    set_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    send_probe_text();
    set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_probe_text();
    set_regs(16'd1, 16'hFFFF, 16'd2, 16'hFFFE, 16'd3);
    send_probe_text();
    // indexes past the list must leave the registers alone
    write_reg(REG_WORD_GAP + 3'd1, 16'h5A5A);
    write_reg(3'd6, 16'hA5A5);
    write_reg(3'd7, 16'hFFFF);
    cfg_we <= 1'b0;
    send_probe_text();
  endtask

  // Random text under one idle mix, fresh register values first
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int items);
    set_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
             16'($urandom_range(65535)), 16'($urandom_range(65535)),
             16'($urandom_range(65535)));
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    repeat (items) send_char(pick_char(), $urandom_range(5) == 0);
    drain_results();
  endtask

  // Long receiver hold-off while characters keep coming
  task automatic test_output_backpressure();
    send_idle   = 0;
    recv_stall  = 0;
    hold_cycles <= HOLD_OFF_CYCLES;
    repeat (15) send_char(pick_char(), $urandom_range(4) == 0);
    drain_results();
  endtask

  // Receiver side ready, with random stalls and the forced hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Compare each segment word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_segs.size() == 0) begin
        $error("unexpected segment: key_level %0d duration %0d run_last %0d",
               out_tuser, out_tdata, out_tlast);
        failed = 1'b1;
      end else begin
        want_seg = pending_segs.pop_front();
        if (out_tuser !== want_seg.level) begin
          $error("key_level mismatch: expected %0d, got %0d", want_seg.level, out_tuser);
          failed = 1'b1;
        end
        if (out_tdata !== want_seg.dur) begin
          $error("duration mismatch: expected %0d, got %0d", want_seg.dur, out_tdata);
          failed = 1'b1;
        end
        if (out_tlast !== want_seg.last) begin
          $error("run_last mismatch: expected %0d, got %0d", want_seg.last, out_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_phase(0, 0, 11);
    test_random_phase(55, 0, 11);
    test_random_phase(0, 55, 11);
    test_random_phase(28, 28, 11);
    test_output_backpressure();
    if (!failed)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
